/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/ipdd_pkg.sv */
// ----------------------------------------------------------------------------
// ipdd_pkg
// Types and constants shared by the pulse distance decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipdd_pkg;

    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NUM_BYTES  = 4;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned APB_AW     = 5;
    localparam int unsigned APB_DW     = 32;

    localparam logic [INTERVAL_W-1:0] LEAD_MIN_RST  = 16'd11500;
    localparam logic [INTERVAL_W-1:0] LEAD_MAX_RST  = 16'd13500;
    localparam logic [INTERVAL_W-1:0] ZERO_MIN_RST  = 16'd700;
    localparam logic [INTERVAL_W-1:0] BIT_SPLIT_RST = 16'd1550;
    localparam logic [INTERVAL_W-1:0] ONE_MAX_RST   = 16'd2600;

    // Register index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_LEAD_MIN  = 3'd0,
        REG_LEAD_MAX  = 3'd1,
        REG_ZERO_MIN  = 3'd2,
        REG_BIT_SPLIT = 3'd3,
        REG_ONE_MAX   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] lead_min;
        logic [INTERVAL_W-1:0] lead_max;
        logic [INTERVAL_W-1:0] zero_min;
        logic [INTERVAL_W-1:0] bit_split;
        logic [INTERVAL_W-1:0] one_max;
    } cfg_t;

    typedef struct packed {
        logic lead;
        logic one;
        logic zero;
    } pulse_class_t;

endpackage

`default_nettype wire

/* rtl/core/ipdd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ipdd_cfg_regs
// APB register file holding the lead window and bit band thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipdd_cfg_regs
    import ipdd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t        cfg_reg;
    logic [2:0]  idx;
    logic        wr_en;
    logic [INTERVAL_W-1:0] rd_val;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lead_min  <= LEAD_MIN_RST;
            cfg_reg.lead_max  <= LEAD_MAX_RST;
            cfg_reg.zero_min  <= ZERO_MIN_RST;
            cfg_reg.bit_split <= BIT_SPLIT_RST;
            cfg_reg.one_max   <= ONE_MAX_RST;
        end else if (wr_en) begin
            case (idx)
                REG_LEAD_MIN:  cfg_reg.lead_min  <= pwdata[INTERVAL_W-1:0];
                REG_LEAD_MAX:  cfg_reg.lead_max  <= pwdata[INTERVAL_W-1:0];
                REG_ZERO_MIN:  cfg_reg.zero_min  <= pwdata[INTERVAL_W-1:0];
                REG_BIT_SPLIT: cfg_reg.bit_split <= pwdata[INTERVAL_W-1:0];
                REG_ONE_MAX:   cfg_reg.one_max   <= pwdata[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LEAD_MIN:  rd_val = cfg_reg.lead_min;
            REG_LEAD_MAX:  rd_val = cfg_reg.lead_max;
            REG_ZERO_MIN:  rd_val = cfg_reg.zero_min;
            REG_BIT_SPLIT: rd_val = cfg_reg.bit_split;
            REG_ONE_MAX:   rd_val = cfg_reg.one_max;
            default:       rd_val = '0;
        endcase
        prdata = {{(APB_DW-INTERVAL_W){1'b0}}, rd_val};
    end

endmodule

`default_nettype wire

/* rtl/core/ipdd_classify.sv */
// ----------------------------------------------------------------------------
// ipdd_classify
// Sorts one edge interval into lead window, one band or zero band.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipdd_classify
    import ipdd_pkg::*;
(
    input  wire cfg_t                   cfg,
    input  wire logic [INTERVAL_W-1:0]  interval,
    output pulse_class_t                cls
);

    // All bounds are exclusive; an empty window simply never matches
    always_comb begin
        cls.lead = (interval > cfg.lead_min)  && (interval < cfg.lead_max);
        cls.one  = (interval > cfg.bit_split) && (interval < cfg.one_max);
        cls.zero = (interval > cfg.zero_min)  && (interval < cfg.bit_split);
    end

endmodule

`default_nettype wire

/* rtl/core/ipdd_frame.sv */
// ----------------------------------------------------------------------------
// ipdd_frame
// Frame state, byte shift register and registered result slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipdd_frame
    import ipdd_pkg::*;
#(
    parameter int unsigned FRAME_BITS = 32
)
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire pulse_class_t      cls,
    output logic                   item_take,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BYTE_W-1:0]      m_address,
    output logic [BYTE_W-1:0]      m_address_inv,
    output logic [BYTE_W-1:0]      m_command,
    output logic [BYTE_W-1:0]      m_command_inv,
    output logic                   m_code_ok
);

    localparam logic [CNT_W-1:0] FRAME_END = CNT_W'(FRAME_BITS);

    logic                   in_frame_reg,  in_frame_next;
    logic [CNT_W-1:0]       bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]      bytes_reg  [NUM_BYTES];
    logic [BYTE_W-1:0]      bytes_next [NUM_BYTES];
    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]      out_bytes_reg [NUM_BYTES];
    logic                   out_ok_reg;
    logic                   emit;
    logic                   shift_en;
    logic [1:0]             byte_sel;
    logic [CNT_W-1:0]       count_inc;

    // Take the next item whenever the result slot is free or being drained
    assign item_take = item_valid && (!out_valid_reg || m_ready);
    assign shift_en  = item_take && !cls.lead && in_frame_reg && (cls.one || cls.zero);
    assign byte_sel  = bit_count_reg[4:3];
    assign count_inc = bit_count_reg + CNT_W'(1);
    assign emit      = shift_en && (count_inc == FRAME_END);

    always_comb begin
        in_frame_next  = in_frame_reg;
        bit_count_next = bit_count_reg;
        for (int i = 0; i < NUM_BYTES; i++) begin
            bytes_next[i] = bytes_reg[i];
            if (shift_en && (byte_sel == 2'(i))) begin
                bytes_next[i] = {cls.one, bytes_reg[i][BYTE_W-1:1]};
            end
        end
        if (item_take && cls.lead) begin
            // Lead restarts the frame, byte contents stay
            in_frame_next  = 1'b1;
            bit_count_next = '0;
        end else if (emit) begin
            in_frame_next  = 1'b0;
            bit_count_next = '0;
        end else if (shift_en) begin
            bit_count_next = count_inc;
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            bit_count_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BYTES; i++) begin
                bytes_reg[i] <= '0;
            end
        end else begin
            in_frame_reg  <= in_frame_next;
            bit_count_reg <= bit_count_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_BYTES; i++) begin
                bytes_reg[i] <= bytes_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            for (int i = 0; i < NUM_BYTES; i++) begin
                out_bytes_reg[i] <= bytes_next[i];
            end
            out_ok_reg <= (bytes_next[2] == ~bytes_next[3]);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_address     = out_bytes_reg[0];
    assign m_address_inv = out_bytes_reg[1];
    assign m_command     = out_bytes_reg[2];
    assign m_command_inv = out_bytes_reg[3];
    assign m_code_ok     = out_ok_reg;

endmodule

`default_nettype wire

/* rtl/core/ir_pulse_distance_decoder.sv */
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder
// NEC-style infrared remote decoder working on edge-to-edge timer counts.
// ----------------------------------------------------------------------------
// Each input transfer carries the timer count between two receiver edges. A
// count inside the lead window opens a frame; inside a frame, counts in the
// one or zero band shift bits into four bytes, LSB first. After FRAME_BITS
// bits one result transfer carries the four bytes and code_ok, which is set
// when command equals the inverse of command_inv. The block accepts one edge
// per clock while not stalled: an edge is registered in the input register,
// classified and folded into the frame state; the frame-closing edge writes
// the result register. Input stalls only while a finished result waits in
// the output register. Thresholds are set over APB; the user writes them only
// while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ir_pulse_distance_decoder
    import ipdd_pkg::*;
#(
    parameter int unsigned FRAME_BITS = 32
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic      [APB_DW-1:0]     prdata,
    output logic                       pready,
    // edge intervals
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [INTERVAL_W-1:0] s_interval,
    // decoded frames
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [BYTE_W-1:0]     m_address,
    output logic      [BYTE_W-1:0]     m_address_inv,
    output logic      [BYTE_W-1:0]     m_command,
    output logic      [BYTE_W-1:0]     m_command_inv,
    output logic                       m_code_ok
);

    cfg_t                   cfg;
    pulse_class_t           cls;
    logic                   in_valid_reg, in_valid_next;
    logic [INTERVAL_W-1:0]  interval_reg;
    logic                   item_take;

    assign s_ready = !in_valid_reg || item_take;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (item_take) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            interval_reg <= s_interval;
        end
    end

    ipdd_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipdd_classify u_classify (
        .cfg      (cfg),
        .interval (interval_reg),
        .cls      (cls)
    );

    ipdd_frame #(
        .FRAME_BITS (FRAME_BITS)
    ) u_frame (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (in_valid_reg),
        .cls           (cls),
        .item_take     (item_take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_address     (m_address),
        .m_address_inv (m_address_inv),
        .m_command     (m_command),
        .m_command_inv (m_command_inv),
        .m_code_ok     (m_code_ok)
    );

    // A transfer on the input always lands in the input register
    `ASSERT_NEXT(a_in_capture, aclk, aresetn, s_valid && s_ready, in_valid_reg)
    // A blocked result must hold back a pending edge
    `ASSERT_IMPL(a_stall_hold, aclk, aresetn, in_valid_reg && m_valid && !m_ready, !s_ready)
    // The check flag matches the bytes it travels with
    `ASSERT_IMPL(a_code_ok, aclk, aresetn, m_valid, m_code_ok == (m_command == ~m_command_inv))

endmodule

`default_nettype wire
